/* design/bba_pkg.sv */
// ----------------------------------------------------------------------------
// bba_pkg
// shared types and field widths of the buddy block allocator
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int unsigned BYTES_W      = 32;
  localparam int unsigned PAGE_FIELD_W = 10;
  localparam int unsigned ORDER_FIELD_W = 4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ORDER,
    ST_SCAN,
    ST_POP,
    ST_PUSH_LO,
    ST_PUSH_HI,
    ST_FINAL,
    ST_RESULT
  } bba_state_t;

endpackage

/* design/bba_if.sv */
// ----------------------------------------------------------------------------
// bba interfaces
// request and grant channels with valid / ready handshake
// ----------------------------------------------------------------------------
interface bba_req_if;
  logic                             valid;
  logic                             ready;
  logic [bba_pkg::BYTES_W-1:0]      request_bytes;

  modport source (output valid, output request_bytes, input ready);
  modport sink   (input valid, input request_bytes, output ready);
endinterface

interface bba_grant_if;
  logic                               valid;
  logic                               ready;
  logic                               granted;
  logic [bba_pkg::PAGE_FIELD_W-1:0]   block_page;
  logic [bba_pkg::ORDER_FIELD_W-1:0]  block_order;

  modport source (output valid, output granted, output block_page, output block_order,
                  input ready);
  modport sink   (input valid, input granted, input block_page, input block_order,
                  output ready);
endinterface

/* design/bba_slot_ram.sv */
// ----------------------------------------------------------------------------
// bba_slot_ram
// free stack storage: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module bba_slot_ram #(
  parameter int unsigned AW = 11,
  parameter int unsigned DW = 10
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* design/buddy_block_allocator_unit.sv */
// ----------------------------------------------------------------------------
// buddy_block_allocator_unit
// buddy allocator: rounds a byte request to a power-of-two page order and
// pops or splits blocks from per-order free stacks held in a slot memory
// ----------------------------------------------------------------------------
// Channels: req carries request_bytes; grant returns granted, block_page and
// block_order, one grant transfer per request transfer, in request order.
// One request is worked on at a time. With n the needed order and s the
// lowest order at or above n with a free block, a request passes from its
// transfer to the output register by sizing the request, one scan step per
// order from n to s, a pop read, a lower push and an upper push for each
// split, and one final pop read. An oversized request goes from sizing
// straight to the result; one that finds no free block scans up to the top
// order first. These steps follow from the single port pair of the slot
// memory and the order scan of the stack counters.
// The result sits in an output register; a new request is taken while it
// waits. If the receiver stalls, the next result is held in the sequencer
// until the output register is free, and no further request is taken.
// Reset clears the stack counters so that the top order holds its single
// block at page zero; the slot memory is not cleared and needs no pass.
// ----------------------------------------------------------------------------
module buddy_block_allocator_unit #(
  parameter int unsigned TOP_ORDER  = 10,
  parameter int unsigned PAGE_BYTES = 4096
) (
  input  logic        clk,
  input  logic        rst,
  bba_req_if.sink     req,
  bba_grant_if.source grant
);

  localparam int unsigned PW = TOP_ORDER;
  localparam int unsigned AW = TOP_ORDER + 1;
  localparam int unsigned CW = TOP_ORDER + 1;
  localparam int unsigned OW = $clog2(TOP_ORDER + 1);
  localparam int unsigned SW = $clog2(TOP_ORDER + 2);

  bba_pkg::bba_state_t state, state_next;

  logic [bba_pkg::BYTES_W-1:0] bytes_reg;
  logic [OW-1:0]               need;
  logic [OW-1:0]               k;
  logic [PW-1:0]               blk;
  logic                        ok;
  logic [CW-1:0]               counts [TOP_ORDER+1];

  logic                                grant_valid;
  logic                                res_granted;
  logic [bba_pkg::PAGE_FIELD_W-1:0]    res_page;
  logic [bba_pkg::ORDER_FIELD_W-1:0]   res_order;

  logic                accept;
  logic [TOP_ORDER:0]  lt;
  logic [OW-1:0]       need_calc;
  logic                oversize;
  logic [OW-1:0]       km1;
  logic [OW-1:0]       idx;
  logic [CW-1:0]       cnt;
  logic [SW-1:0]       base_sh;
  logic [AW-1:0]       base;
  logic [CW-1:0]       cap;
  logic                full;
  logic [PW-1:0]       src;
  logic [PW-1:0]       half;
  logic                out_free;

  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  logic [PW-1:0]       rd_data;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [PW-1:0]       wr_data;
  logic                cnt_inc;
  logic                cnt_dec;
  logic                load_res;

  logic [PW+bba_pkg::PAGE_FIELD_W-1:0]  page_ext;
  logic [OW+bba_pkg::ORDER_FIELD_W-1:0] order_ext;

  bba_slot_ram #(
    .AW (AW),
    .DW (PW)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign req.ready = (state == bba_pkg::ST_IDLE);
  assign accept    = req.valid && req.ready;
  assign out_free  = !grant_valid || grant.ready;

  // request size against page thresholds of each order
  always_comb begin
    for (int i = 0; i <= TOP_ORDER; i++) begin
      lt[i] = {32'b0, bytes_reg} > (64'(PAGE_BYTES) << i);
    end
    need_calc = OW'(TOP_ORDER);
    for (int i = TOP_ORDER; i >= 0; i--) begin
      if (!lt[i]) begin
        need_calc = OW'(i);
      end
    end
    oversize = lt[TOP_ORDER];
  end

  assign km1 = k - OW'(1);
  assign idx = (state == bba_pkg::ST_PUSH_LO || state == bba_pkg::ST_PUSH_HI) ? km1 : k;
  assign cnt = counts[idx];

  assign base_sh = SW'(TOP_ORDER + 1) - SW'(idx);
  assign base    = {AW{1'b1}} << base_sh;
  assign cap     = CW'(1) << (SW'(TOP_ORDER) - SW'(idx));
  assign full    = cnt >= cap;

  // the top stack only ever holds the block at page zero
  assign src  = (k == OW'(TOP_ORDER)) ? '0 : rd_data;
  assign half = PW'(1) << km1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bba_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    rd_en      = 1'b0;
    rd_addr    = base + AW'(cnt) - AW'(1);
    wr_en      = 1'b0;
    wr_addr    = base + AW'(cnt);
    wr_data    = src;
    cnt_inc    = 1'b0;
    cnt_dec    = 1'b0;
    load_res   = 1'b0;
    unique case (state)
      bba_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = bba_pkg::ST_ORDER;
        end
      end
      bba_pkg::ST_ORDER: begin
        state_next = oversize ? bba_pkg::ST_RESULT : bba_pkg::ST_SCAN;
      end
      bba_pkg::ST_SCAN: begin
        if (cnt != '0) begin
          state_next = (k == need) ? bba_pkg::ST_FINAL : bba_pkg::ST_POP;
        end else if (k == OW'(TOP_ORDER)) begin
          state_next = bba_pkg::ST_RESULT;
        end
      end
      bba_pkg::ST_POP: begin
        rd_en      = 1'b1;
        cnt_dec    = 1'b1;
        state_next = bba_pkg::ST_PUSH_LO;
      end
      bba_pkg::ST_PUSH_LO: begin
        wr_en      = !full;
        cnt_inc    = !full;
        wr_data    = src;
        state_next = bba_pkg::ST_PUSH_HI;
      end
      bba_pkg::ST_PUSH_HI: begin
        wr_en      = !full;
        cnt_inc    = !full;
        wr_data    = blk + half;
        state_next = (km1 == need) ? bba_pkg::ST_FINAL : bba_pkg::ST_POP;
      end
      bba_pkg::ST_FINAL: begin
        rd_en      = 1'b1;
        cnt_dec    = 1'b1;
        state_next = bba_pkg::ST_RESULT;
      end
      bba_pkg::ST_RESULT: begin
        if (out_free) begin
          load_res   = 1'b1;
          state_next = bba_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = bba_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= TOP_ORDER; i++) begin
        counts[i] <= (i == TOP_ORDER) ? CW'(1) : '0;
      end
    end else if (cnt_dec) begin
      counts[idx] <= cnt - CW'(1);
    end else if (cnt_inc) begin
      counts[idx] <= cnt + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      bytes_reg <= req.request_bytes;
    end
    unique case (state)
      bba_pkg::ST_ORDER: begin
        need <= need_calc;
        k    <= need_calc;
        ok   <= 1'b0;
      end
      bba_pkg::ST_SCAN: begin
        if (cnt == '0 && k != OW'(TOP_ORDER)) begin
          k <= k + OW'(1);
        end
      end
      bba_pkg::ST_PUSH_LO: begin
        blk <= src;
      end
      bba_pkg::ST_PUSH_HI: begin
        k <= km1;
      end
      bba_pkg::ST_FINAL: begin
        ok <= 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign page_ext  = {{bba_pkg::PAGE_FIELD_W{1'b0}}, src};
  assign order_ext = {{bba_pkg::ORDER_FIELD_W{1'b0}}, need};

  always_ff @(posedge clk) begin
    if (rst) begin
      grant_valid <= 1'b0;
    end else if (load_res) begin
      grant_valid <= 1'b1;
    end else if (grant.ready) begin
      grant_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_res) begin
      res_granted <= ok;
      res_page    <= ok ? page_ext[bba_pkg::PAGE_FIELD_W-1:0] : '0;
      res_order   <= ok ? order_ext[bba_pkg::ORDER_FIELD_W-1:0] : '0;
    end
  end

  assign grant.valid       = grant_valid;
  assign grant.granted     = res_granted;
  assign grant.block_page  = res_page;
  assign grant.block_order = res_order;

  a_top_count: assert property (@(posedge clk) disable iff (rst)
    counts[TOP_ORDER] <= CW'(1))
    else $error("top order stack holds more than one block");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    grant.valid && !grant.granted |-> grant.block_page == '0 && grant.block_order == '0)
    else $error("failed grant carries nonzero fields");

  a_final_order: assert property (@(posedge clk) disable iff (rst)
    state == bba_pkg::ST_FINAL |-> k == need)
    else $error("final pop not at the needed order");

  a_split_above: assert property (@(posedge clk) disable iff (rst)
    state == bba_pkg::ST_PUSH_HI |-> k > need)
    else $error("split at or below the needed order");

endmodule

/* sim/buddy_block_allocator_unit_tb.sv */
// ----------------------------------------------------------------------------
// buddy_block_allocator_unit_tb
// Sends byte-sized allocation requests and checks every grant against an
// internal model of the heap: per-order free stacks that are split on demand.
// The run starts with directed edge cases, then random requests weighted
// toward small orders so that the heap is used up gradually. Both channels
// idle at random. The grant side also holds off once for a long stretch.
// ----------------------------------------------------------------------------
module buddy_block_allocator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TOP_ORDER    = 10;
  localparam int unsigned PAGE_BYTES   = 4096;
  localparam int unsigned RANDOM_ITEMS = 1335;
  localparam int unsigned HOLD_AFTER   = 400;
  localparam int unsigned HOLD_CYCLES  = 600;
  localparam int unsigned DRAIN_CYCLES = 64;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam longint unsigned CYCLE_LIMIT = 1000000;

  typedef logic [bba_pkg::BYTES_W-1:0]       bytes_t;
  typedef logic [bba_pkg::PAGE_FIELD_W-1:0]  page_t;
  typedef logic [bba_pkg::ORDER_FIELD_W-1:0] order_t;

  typedef struct packed {
    logic   granted;
    page_t  page;
    order_t order;
  } grant_t;

  class heap_tracker;
    page_t       free_blocks[TOP_ORDER+1][$];
    grant_t      awaited_grants[$];
    int unsigned mismatches;

    function new();
      free_blocks[TOP_ORDER].push_back('0);
      mismatches = 0;
    endfunction

    function int unsigned order_of(bytes_t bytes);
      longint unsigned pages;
      int unsigned     k;
      pages = (longint'(bytes) + PAGE_BYTES - 1) / PAGE_BYTES;
      k = 0;
      while (k < 63 && (64'd1 << k) < pages) k++;
      return k;
    endfunction

    function void push_block(int unsigned k, page_t page);
      if (free_blocks[k].size() < (1 << (TOP_ORDER - k))) free_blocks[k].push_back(page);
    endfunction

    function void note_request(bytes_t bytes);
      grant_t      g;
      int unsigned need;
      int unsigned k;
      page_t       blk;
      g = '0;
      need = order_of(bytes);
      if (need <= TOP_ORDER) begin
        k = need;
        while (k <= TOP_ORDER && free_blocks[k].size() == 0) k++;
        if (k <= TOP_ORDER) begin
          while (k > need) begin
            blk = free_blocks[k].pop_back();
            push_block(k - 1, blk);
            push_block(k - 1, blk + (page_t'(1) << (k - 1)));
            k--;
          end
          g.granted = 1'b1;
          g.page    = free_blocks[need].pop_back();
          g.order   = order_t'(need);
        end
      end
      awaited_grants.push_back(g);
    endfunction

    function void check_grant(grant_t got);
      grant_t want;
      if (awaited_grants.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected grant: granted=%0d page=%0d order=%0d",
                   got.granted, got.page, got.order);
        return;
      end
      want = awaited_grants.pop_front();
      if (got.granted !== want.granted || got.page !== want.page ||
          got.order !== want.order) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display({"grant mismatch: expected granted=%0d page=%0d order=%0d, ",
                    "got granted=%0d page=%0d order=%0d"},
                   want.granted, want.page, want.order,
                   got.granted, got.page, got.order);
      end
    endfunction

    function int unsigned pending();
      return awaited_grants.size();
    endfunction
  endclass

  logic            clk;
  logic            rst;
  longint unsigned cycle_count = 0;
  bit              hold_grants;
  bit              req_busy;
  bit              grant_busy;
  heap_tracker     heap;

  bba_req_if   req_ch ();
  bba_grant_if grant_ch ();

  buddy_block_allocator_unit #(
    .TOP_ORDER  (TOP_ORDER),
    .PAGE_BYTES (PAGE_BYTES)
  ) dut (
    .clk   (clk),
    .rst   (rst),
    .req   (req_ch),
    .grant (grant_ch)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("buddy_block_allocator_unit regression: fail");
      $finish;
    end
  end

  // per-item wait, with occasional switches into stretches without idling
  function automatic int unsigned draw_gap(inout bit busy);
    if ($urandom_range(0, 31) == 0) busy = !busy;
    return busy ? 0 : $urandom_range(0, 18);
  endfunction

  function automatic bytes_t bytes_for_order(int unsigned k);
    longint unsigned lo;
    longint unsigned hi;
    hi = longint'(PAGE_BYTES) << k;
    lo = (k == 0) ? 0 : (longint'(PAGE_BYTES) << (k - 1)) + 1;
    return bytes_t'($urandom_range(32'(lo), 32'(hi)));
  endfunction

  function automatic bytes_t random_request();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 66) return bytes_for_order(0);
    if (pick < 80) return bytes_for_order($urandom_range(1, 3));
    if (pick < 83) return bytes_for_order($urandom_range(4, TOP_ORDER));
    if (pick < 93) return bytes_t'($urandom_range((PAGE_BYTES << TOP_ORDER) + 1, 32'hffff_ffff));
    return bytes_t'($urandom());
  endfunction

  task automatic send_request(input bytes_t bytes);
    int unsigned gap;
    gap = draw_gap(req_busy);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid         <= 1'b1;
    req_ch.request_bytes <= bytes;
    do @(posedge clk); while (!req_ch.ready);
    heap.note_request(bytes);
    @(negedge clk);
  endtask

  initial begin
    int unsigned stall;
    grant_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_grants) begin
        hold_grants = 1'b0;
        stall = HOLD_CYCLES;
      end else begin
        stall = draw_gap(grant_busy);
      end
      if (stall > 0) begin
        grant_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      grant_ch.ready <= 1'b1;
      do @(posedge clk); while (!grant_ch.valid);
      heap.check_grant({grant_ch.granted, grant_ch.block_page, grant_ch.block_order});
      @(negedge clk);
    end
  end

  initial begin
    bytes_t      directed[$];
    int unsigned sent;
    heap         = new();
    hold_grants  = 1'b0;
    req_busy     = 1'b0;
    grant_busy   = 1'b0;
    rst          = 1'b1;
    req_ch.valid         = 1'b0;
    req_ch.request_bytes = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // zero bytes, page boundaries, largest order once the heap is split,
    // just past the largest order, and all ones
    directed = '{32'h0000_0000, 32'h0000_0001, 32'h0000_0fff, 32'h0000_1000,
                 32'h0000_1001, 32'h0000_2000, 32'h0000_2001, 32'h0000_3000,
                 32'h0040_0000, 32'h0040_0001, 32'hffff_ffff, 32'h8000_0000,
                 32'h0010_0000, 32'h0000_8000, 32'h0000_0000, 32'h0004_0001,
                 32'h0080_0000, 32'h0000_0800};
    sent = 0;
    foreach (directed[i]) begin
      send_request(directed[i]);
      sent++;
    end
    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      send_request(random_request());
      sent++;
      if (sent == HOLD_AFTER) hold_grants = 1'b1;
    end
    req_ch.valid <= 1'b0;

    while (heap.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (heap.mismatches == 0 && heap.pending() == 0) begin
      $display("buddy_block_allocator_unit regression: pass");
    end else begin
      $display("buddy_block_allocator_unit regression: fail");
    end
    $finish;
  end

endmodule
